// ----- rtl/dqrs_pkg.sv -----
// dqrs_pkg: shared types and constants of the dual queue resend scheduler
// used by dual_queue_resend_scheduler and tb_top; no dependencies
`default_nettype none

package dqrs_pkg;

	typedef enum logic [2:0] {
		CMD_TICK       = 3'd0,
		CMD_PUSH_REPLY = 3'd1,
		CMD_PUSH_ACT   = 3'd2,
		CMD_DROP_ACT   = 3'd3,
		CMD_BYTE_SENT  = 3'd4
	} cmd_t;

	typedef enum logic [0:0] {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef enum logic [1:0] {
		REG_RETRY_COUNT = 2'd0,
		REG_RETRY_GAP   = 2'd1,
		REG_BYTE_GAP    = 2'd2
	} reg_idx_t;

	localparam logic [7:0] RETRY_COUNT_RST = 8'd3;
	localparam logic [7:0] RETRY_GAP_RST   = 8'd10;
	localparam logic [7:0] BYTE_GAP_RST    = 8'd2;

	// one queue slot
	typedef struct packed {
		logic [7:0] hid;
		logic [7:0] seq;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ----- rtl/dqrs_ram.sv -----
// dqrs_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module dqrs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/dual_queue_resend_scheduler.sv -----
// dual_queue_resend_scheduler: reply queue with strict priority, active queue with resend
// depends on dqrs_pkg and dqrs_ram
`default_nettype none

// the exec state after an input transfer loads its result into the output register
//   once that register is free; each item passes idle, where the registered ram read
//   of the ring tails lands, then exec with its read-modify-write
// no input is taken in exec, but the next one is taken while a result still waits at
//   the output; the work cycle stalls only when the output register is still full
// reset: pointers, counters, retry state cleared, registers to 3, 10, 2; rings not cleared

module dual_queue_resend_scheduler #(
	parameter int QUEUE_DEPTH = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	// input channel
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] cmd,
	input  wire logic [7:0] handler_id,
	input  wire logic [7:0] seq_num,
	// output channel
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            fire,
	output logic      [7:0] fire_handler,
	output logic      [7:0] fire_seq,
	output logic            from_active,
	output logic            push_dropped,
	output logic      [7:0] feedback_info
);

	import dqrs_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

	// configuration registers
	logic [7:0] retry_count_q, retry_gap_q, byte_gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_count_q <= RETRY_COUNT_RST;
			retry_gap_q   <= RETRY_GAP_RST;
			byte_gap_q    <= BYTE_GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RETRY_COUNT: retry_count_q <= cfg_data;
				REG_RETRY_GAP:   retry_gap_q   <= cfg_data;
				REG_BYTE_GAP:    byte_gap_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer: idle takes a transfer, exec does the read-modify-write
	state_t state_q, state_d;
	logic   exec_done;

	assign exec_done = (state_q == ST_EXEC) && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (exec_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// captured item
	logic [2:0] cmd_s1;
	logic [7:0] hid_s1, seq_s1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd;
			hid_s1 <= handler_id;
			seq_s1 <= seq_num;
		end
	end

	// ring pointers: head is the write index, tail the read index
	logic [AW-1:0] reply_head_q, reply_tail_q, act_head_q, act_tail_q;
	logic [AW-1:0] reply_head_d, reply_tail_d, act_head_d, act_tail_d;
	logic [7:0]    send_wait_q, resend_wait_q, retries_q, last_seq_q, info_q;
	logic [7:0]    send_wait_d, resend_wait_d, retries_d, last_seq_d, info_d;

	// rams read at the tail every cycle; writes land only on exec_done, after
	// which the block returns to idle, so a read never overlaps a pending write
	entry_t reply_rdata, act_rdata, wr_entry;
	logic   reply_we, act_we;

	assign wr_entry = '{hid: hid_s1, seq: seq_s1};

	dqrs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_reply_ram (
		.clk   (clk),
		.we    (reply_we),
		.waddr (reply_head_q),
		.wdata (wr_entry),
		.raddr (reply_tail_q),
		.rdata (reply_rdata)
	);

	dqrs_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_act_ram (
		.clk   (clk),
		.we    (act_we),
		.waddr (act_head_q),
		.wdata (wr_entry),
		.raddr (act_tail_q),
		.rdata (act_rdata)
	);

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == LAST_IDX) ? '0 : p + AW'(1);
	endfunction

	logic reply_empty, act_empty, reply_full, act_full;

	assign reply_empty = (reply_head_q == reply_tail_q);
	assign act_empty   = (act_head_q == act_tail_q);
	assign reply_full  = (ptr_next(reply_head_q) == reply_tail_q);
	assign act_full    = (ptr_next(act_head_q) == act_tail_q);

	logic       fire_d, from_active_d, dropped_d;
	logic [7:0] fh_d, fs_d, rl;

	always_comb begin
		reply_head_d  = reply_head_q;
		reply_tail_d  = reply_tail_q;
		act_head_d    = act_head_q;
		act_tail_d    = act_tail_q;
		send_wait_d   = send_wait_q;
		resend_wait_d = resend_wait_q;
		retries_d     = retries_q;
		last_seq_d    = last_seq_q;
		info_d        = info_q;
		reply_we      = 1'b0;
		act_we        = 1'b0;
		fire_d        = 1'b0;
		fh_d          = '0;
		fs_d          = '0;
		from_active_d = 1'b0;
		dropped_d     = 1'b0;
		rl            = retries_q;
		if (exec_done) begin
			case (cmd_s1)
				CMD_TICK: begin
					if (send_wait_q != '0) begin
						send_wait_d = send_wait_q - 8'd1;
					end else if (!reply_empty) begin
						// reply entries go out once
						fire_d       = 1'b1;
						fh_d         = reply_rdata.hid;
						fs_d         = reply_rdata.seq;
						reply_tail_d = ptr_next(reply_tail_q);
					end else if (resend_wait_q != '0) begin
						resend_wait_d = resend_wait_q - 8'd1;
					end else if (!act_empty) begin
						// a new sequence number reloads the retries
						if (act_rdata.seq != last_seq_q) begin
							rl         = retry_count_q;
							last_seq_d = act_rdata.seq;
							info_d     = act_rdata.seq;
						end
						if (rl != '0) begin
							retries_d     = rl - 8'd1;
							fire_d        = 1'b1;
							fh_d          = act_rdata.hid;
							fs_d          = act_rdata.seq;
							from_active_d = 1'b1;
							resend_wait_d = retry_gap_q;
						end else begin
							retries_d  = rl;
							act_tail_d = ptr_next(act_tail_q);
							info_d     = '0;
						end
					end
				end
				CMD_PUSH_REPLY: begin
					if (reply_full) begin
						dropped_d = 1'b1;
					end else begin
						reply_we     = 1'b1;
						reply_head_d = ptr_next(reply_head_q);
					end
				end
				CMD_PUSH_ACT: begin
					if (act_full) begin
						dropped_d = 1'b1;
					end else begin
						act_we     = 1'b1;
						act_head_d = ptr_next(act_head_q);
					end
				end
				CMD_DROP_ACT: begin
					if (!act_empty) begin
						act_tail_d = ptr_next(act_tail_q);
					end
				end
				CMD_BYTE_SENT: begin
					send_wait_d = byte_gap_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_head_q  <= '0;
			reply_tail_q  <= '0;
			act_head_q    <= '0;
			act_tail_q    <= '0;
			send_wait_q   <= '0;
			resend_wait_q <= '0;
			retries_q     <= '0;
			last_seq_q    <= '0;
			info_q        <= '0;
		end else begin
			reply_head_q  <= reply_head_d;
			reply_tail_q  <= reply_tail_d;
			act_head_q    <= act_head_d;
			act_tail_q    <= act_tail_d;
			send_wait_q   <= send_wait_d;
			resend_wait_q <= resend_wait_d;
			retries_q     <= retries_d;
			last_seq_q    <= last_seq_d;
			info_q        <= info_d;
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_done) begin
			fire          <= fire_d;
			fire_handler  <= fh_d;
			fire_seq      <= fs_d;
			from_active   <= from_active_d;
			push_dropped  <= dropped_d;
			feedback_info <= info_d;
		end
	end

	assign out_valid = out_valid_q;

	// a finished item always shows up at the output next cycle
	a_exec_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		exec_done |=> out_valid)
		else $error("work cycle did not load the output register");

	// a push never fires and a tick never reports a drop
	a_fire_xor_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(fire && push_dropped))
		else $error("fire and push_dropped both set");

	// an idle result carries zero fire fields
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !fire) |-> (fire_handler == '0 && fire_seq == '0 && !from_active))
		else $error("fire fields not cleared");

	// an active transmission always reports its own sequence as feedback
	a_active_info: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && from_active) |-> (feedback_info == fire_seq))
		else $error("feedback info differs from active sequence");

	// pointers stay inside the ring for any depth
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(reply_head_q <= LAST_IDX) && (reply_tail_q <= LAST_IDX) &&
		(act_head_q <= LAST_IDX) && (act_tail_q <= LAST_IDX))
		else $error("ring pointer out of range");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking bench for dual_queue_resend_scheduler, directed table then random traffic
// keeps its own model of both send rings, the wait counters and the retry state
// depends on dqrs_pkg and the scheduler rtl
module tb_top;
	import dqrs_pkg::*;

	localparam int DEPTH = 8;

	// queue selectors for the model rings
	localparam int Q_REPLY  = 0;
	localparam int Q_ACTIVE = 1;

	// command codes the block ignores
	localparam logic [2:0] CMD_RSVD_5 = 3'd5;
	localparam logic [2:0] CMD_RSVD_6 = 3'd6;
	localparam logic [2:0] CMD_RSVD_7 = 3'd7;

	// the longest quiet stretch of a correct run is a long sender gap plus a long
	// receiver stall, a register write and the pipe latency
	localparam int QUIET_LIMIT = 1000;

	// random items per configuration phase, reserved codes not counted
	localparam int PHASE_ITEMS = 270;
	localparam int NUM_PHASES  = 7;

	// one scheduler output as seen on the result channel
	typedef struct packed {
		logic       fire;
		logic [7:0] handler;
		logic [7:0] seq;
		logic       active;
		logic       dropped;
		logic [7:0] info;
	} sched_out_t;

	localparam sched_out_t NOTHING = '0;

	// one row of the directed table
	typedef struct packed {
		logic [2:0] c;
		logic [7:0] h;
		logic [7:0] s;
		logic       typed;
		sched_out_t want;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	reg_idx_t   cfg_index;
	logic [7:0] cfg_data;
	logic       in_valid;
	logic       in_ready;
	logic [2:0] cmd;
	logic [7:0] handler_id;
	logic [7:0] seq_num;
	logic       out_valid;
	logic       out_ready;
	logic       fire;
	logic [7:0] fire_handler;
	logic [7:0] fire_seq;
	logic       from_active;
	logic       push_dropped;
	logic [7:0] feedback_info;

	dual_queue_resend_scheduler #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.handler_id   (handler_id),
		.seq_num      (seq_num),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.fire         (fire),
		.fire_handler (fire_handler),
		.fire_seq     (fire_seq),
		.from_active  (from_active),
		.push_dropped (push_dropped),
		.feedback_info(feedback_info)
	);

	// model state: both rings, wait counters, retry bookkeeping
	entry_t     queue_mem [2][DEPTH];
	int         q_wr [2];
	int         q_rd [2];
	logic [7:0] send_wait;
	logic [7:0] resend_wait;
	logic [7:0] retries_left;
	logic [7:0] last_seq;
	logic [7:0] info_reg;

	// model copy of the configuration registers
	logic [7:0] retry_count;
	logic [7:0] retry_gap;
	logic [7:0] byte_gap;

	// outputs still owed by the block, oldest first
	sched_out_t sched_outputs [$];
	stim_row_t  directed [$];

	int errors;
	int quiet_cycles;
	int stall_left;
	bit no_idle;

	// clock, period 10
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int ring_next(input int p);
		return (p + 1 >= DEPTH) ? 0 : p + 1;
	endfunction

	// push into ring q, 0 when the ring is full (one slot always stays free)
	function automatic bit ring_push(input int q, input logic [7:0] h, input logic [7:0] s);
		int n;
		n = ring_next(q_wr[q]);
		if (n == q_rd[q])
			return 1'b0;
		queue_mem[q][q_wr[q]].hid = h;
		queue_mem[q][q_wr[q]].seq = s;
		q_wr[q] = n;
		return 1'b1;
	endfunction

	// one step of the scheduler: updates the model state, returns its output
	function automatic sched_out_t run_scheduler(input logic [2:0] c, input logic [7:0] h,
		input logic [7:0] s);
		sched_out_t o;
		entry_t     e;
		o = NOTHING;
		case (c)
			CMD_TICK: begin
				// byte quiet time beats everything, then replies, then resend wait
				if (send_wait != 8'd0) begin
					send_wait = send_wait - 8'd1;
				end else if (q_wr[Q_REPLY] != q_rd[Q_REPLY]) begin
					e = queue_mem[Q_REPLY][q_rd[Q_REPLY]];
					o.fire = 1'b1;
					o.handler = e.hid;
					o.seq = e.seq;
					q_rd[Q_REPLY] = ring_next(q_rd[Q_REPLY]);
				end else if (resend_wait != 8'd0) begin
					resend_wait = resend_wait - 8'd1;
				end else if (q_wr[Q_ACTIVE] != q_rd[Q_ACTIVE]) begin
					e = queue_mem[Q_ACTIVE][q_rd[Q_ACTIVE]];
					// a new sequence number reloads the retries and shows as feedback
					if (e.seq != last_seq) begin
						retries_left = retry_count;
						last_seq = e.seq;
						info_reg = e.seq;
					end
					if (retries_left != 8'd0) begin
						retries_left = retries_left - 8'd1;
						o.fire = 1'b1;
						o.handler = e.hid;
						o.seq = e.seq;
						o.active = 1'b1;
						resend_wait = retry_gap;
					end else begin
						q_rd[Q_ACTIVE] = ring_next(q_rd[Q_ACTIVE]);
						info_reg = 8'd0;
					end
				end
			end
			CMD_PUSH_REPLY: o.dropped = !ring_push(Q_REPLY, h, s);
			CMD_PUSH_ACT:   o.dropped = !ring_push(Q_ACTIVE, h, s);
			CMD_DROP_ACT: begin
				if (q_wr[Q_ACTIVE] != q_rd[Q_ACTIVE])
					q_rd[Q_ACTIVE] = ring_next(q_rd[Q_ACTIVE]);
			end
			CMD_BYTE_SENT:  send_wait = byte_gap;
			default: ;
		endcase
		o.info = info_reg;
		return o;
	endfunction

	function automatic sched_out_t outcome(input logic f, input logic [7:0] h, input logic [7:0] s,
		input logic a, input logic d, input logic [7:0] info);
		sched_out_t o;
		o.fire = f;
		o.handler = h;
		o.seq = s;
		o.active = a;
		o.dropped = d;
		o.info = info;
		return o;
	endfunction

	function automatic void add_row(input logic [2:0] c, input logic [7:0] h, input logic [7:0] s,
		input logic typed, input sched_out_t want);
		stim_row_t r;
		r.c = c;
		r.h = h;
		r.s = s;
		r.typed = typed;
		r.want = want;
		directed.push_back(r);
	endfunction

	// idle length for either side: mostly none, often short, now and then long
	function automatic int idle_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one input transfer; called at a rising edge, returns at a rising edge
	task automatic send_item(input logic [2:0] c, input logic [7:0] h, input logic [7:0] s,
		input logic typed, input sched_out_t want);
		sched_out_t predicted;
		int         gap;
		cmd <= c;
		handler_id <= h;
		seq_num <= s;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		// transfer done at this edge, the model steps here
		predicted = run_scheduler(c, h, s);
		sched_outputs.push_back(typed ? want : predicted);
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// sender holds off until the block has handed back every owed output
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sched_outputs.size() != 0)
			@(posedge clk);
	endtask

	// all three registers, one write per edge, block idle
	task automatic set_timing(input logic [7:0] rc, input logic [7:0] rg, input logic [7:0] bg);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_RETRY_COUNT;
		cfg_data <= rc;
		@(posedge clk);
		cfg_index <= REG_RETRY_GAP;
		cfg_data <= rg;
		@(posedge clk);
		cfg_index <= REG_BYTE_GAP;
		cfg_data <= bg;
		@(posedge clk);
		cfg_we <= 1'b0;
		retry_count = rc;
		retry_gap = rg;
		byte_gap = bg;
	endtask

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// result side: random back-pressure on out_ready
	always @(posedge clk) begin : result_ready
		int n;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			n = idle_len();
			if (n > 0) begin
				stall_left <= n - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// every result transfer is matched against the oldest owed output
	always @(posedge clk) begin : check_results
		sched_out_t want;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (sched_outputs.size() == 0) begin
				$error("result transfer with no output owed");
				errors++;
			end else begin
				want = sched_outputs.pop_front();
				check_field("fire", 8'(want.fire), 8'(fire));
				check_field("fire_handler", want.handler, fire_handler);
				check_field("fire_seq", want.seq, fire_seq);
				check_field("from_active", 8'(want.active), 8'(from_active));
				check_field("push_dropped", 8'(want.dropped), 8'(push_dropped));
				check_field("feedback_info", want.info, feedback_info);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [2:0] c;
		logic [7:0] rc;
		logic [7:0] rg;
		logic [7:0] bg;
		int         r;
		int         done;

		// every input known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_RETRY_COUNT;
		cfg_data = 8'd0;
		in_valid = 1'b0;
		cmd = CMD_TICK;
		handler_id = 8'd0;
		seq_num = 8'd0;
		out_ready = 1'b0;
		stall_left = 0;
		no_idle = 1'b0;
		errors = 0;
		quiet_cycles = 0;

		// model reset
		for (int q = 0; q < 2; q++) begin
			q_wr[q] = 0;
			q_rd[q] = 0;
		end
		send_wait = 8'd0;
		resend_wait = 8'd0;
		retries_left = 8'd0;
		last_seq = 8'd0;
		info_reg = 8'd0;
		retry_count = RETRY_COUNT_RST;
		retry_gap = RETRY_GAP_RST;
		byte_gap = BYTE_GAP_RST;

		// directed table, run with the reset timing
		add_row(CMD_TICK, 8'h00, 8'h00, 1'b1, NOTHING);          // nothing queued after reset
		add_row(CMD_DROP_ACT, 8'h00, 8'h00, 1'b1, NOTHING);      // drop with empty active ring
		add_row(CMD_RSVD_5, 8'h00, 8'h00, 1'b1, NOTHING);        // unused codes are ignored
		add_row(CMD_RSVD_6, 8'hFF, 8'hFF, 1'b1, NOTHING);
		add_row(CMD_RSVD_7, 8'hA5, 8'h5A, 1'b1, NOTHING);
		add_row(CMD_PUSH_ACT, 8'h11, 8'h00, 1'b1, NOTHING);      // seq 0 matches last seq after reset
		add_row(CMD_TICK, 8'h00, 8'h00, 1'b1, NOTHING);          // popped at once, no fire
		// fill the reply ring to capacity, then one more
		add_row(CMD_PUSH_REPLY, 8'hFF, 8'hFF, 1'b1, NOTHING);
		add_row(CMD_PUSH_REPLY, 8'h00, 8'h00, 1'b1, NOTHING);
		add_row(CMD_PUSH_REPLY, 8'h01, 8'h80, 1'b1, NOTHING);
		add_row(CMD_PUSH_REPLY, 8'h55, 8'hAA, 1'b1, NOTHING);
		add_row(CMD_PUSH_REPLY, 8'hAA, 8'h55, 1'b1, NOTHING);
		add_row(CMD_PUSH_REPLY, 8'h7F, 8'h01, 1'b1, NOTHING);
		add_row(CMD_PUSH_REPLY, 8'h80, 8'hFE, 1'b1, NOTHING);
		add_row(CMD_PUSH_REPLY, 8'h12, 8'h34, 1'b1, outcome(1'b0, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00));
		add_row(CMD_TICK, 8'h00, 8'h00, 1'b1, outcome(1'b1, 8'hFF, 8'hFF, 1'b0, 1'b0, 8'h00));
		add_row(CMD_BYTE_SENT, 8'h00, 8'h00, 1'b1, NOTHING);     // starts the byte quiet time
		add_row(CMD_TICK, 8'h00, 8'h00, 1'b0, NOTHING);
		add_row(CMD_TICK, 8'h00, 8'h00, 1'b0, NOTHING);
		add_row(CMD_TICK, 8'h00, 8'h00, 1'b0, NOTHING);
		add_row(CMD_PUSH_ACT, 8'hA5, 8'h01, 1'b0, NOTHING);
		add_row(CMD_PUSH_ACT, 8'h5A, 8'h01, 1'b0, NOTHING);     // same seq, no retry reload
		add_row(CMD_DROP_ACT, 8'h00, 8'h00, 1'b0, NOTHING);
		add_row(CMD_TICK, 8'h00, 8'h00, 1'b0, NOTHING);
		add_row(CMD_TICK, 8'h00, 8'h00, 1'b0, NOTHING);

		// reset once at the start, then release it
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i].c, directed[i].h, directed[i].s, directed[i].typed,
				directed[i].want);

		// random phases, each under its own timing
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results();
			case (p)
				0: begin rc = 8'd0;   rg = 8'd0;   bg = 8'd0;   end
				1: begin rc = 8'd255; rg = 8'd255; bg = 8'd255; end
				2: begin rc = 8'd1;   rg = 8'd0;   bg = 8'd255; end
				3: begin rc = 8'd255; rg = 8'd0;   bg = 8'd0;   end
				4: begin rc = RETRY_COUNT_RST; rg = RETRY_GAP_RST; bg = BYTE_GAP_RST; end
				default: begin
					rc = 8'($urandom_range(0, 5));
					rg = 8'($urandom_range(0, 20));
					bg = 8'($urandom_range(0, 8));
				end
			endcase
			set_timing(rc, rg, bg);
			// two phases run without any idling on either side
			no_idle = (p == 3 || p == 5);
			done = 0;
			while (done < PHASE_ITEMS) begin
				// now and then the sender waits for the block to catch up
				if ($urandom_range(0, 99) == 0)
					drain_results();
				r = $urandom_range(0, 99);
				if (r < 47)
					c = CMD_TICK;
				else if (r < 62)
					c = CMD_PUSH_REPLY;
				else if (r < 80)
					c = CMD_PUSH_ACT;
				else if (r < 86)
					c = CMD_DROP_ACT;
				else if (r < 97)
					c = CMD_BYTE_SENT;
				else
					c = 3'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
				// small sequence numbers often, so repeats of the last one happen
				send_item(c, 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255)),
					1'b0, NOTHING);
				if (c <= CMD_BYTE_SENT)
					done++;
			end
		end

		drain_results();
		no_idle = 1'b0;
		repeat (10) @(posedge clk);
		if (errors == 0 && sched_outputs.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
